// File: rtl/core/twc_pkg.sv
// Shared types, register indexes and microcode table of the translational washout channel.
`default_nettype none

package twc_pkg;

   localparam int POS_WIDTH   = 32;
   localparam int FRAC_SHIFT  = 28;
   localparam int ACC_ALIGN   = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int STEP_W      = 4;

   localparam int LIMIT_RESET     = 642253;
   localparam int POS_HIST_RESET  = 357937206;
   localparam int POS_NORM_RESET  = 90387587;
   localparam int POS_ACC_RESET   = 36156;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_HP_GAIN   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HP_FB_ONE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HP_FB_TWO = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HP_ENABLE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_POS_HIST  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_POS_NORM  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_POS_ACC   = 3'd7;

   // multiplier operand pairs
   localparam logic [2:0] MUL_HP_GAIN  = 3'd0;
   localparam logic [2:0] MUL_HP_FB1   = 3'd1;
   localparam logic [2:0] MUL_HP_FB2   = 3'd2;
   localparam logic [2:0] MUL_POS_HIST = 3'd3;
   localparam logic [2:0] MUL_POS_NORM = 3'd4;
   localparam logic [2:0] MUL_POS_ACC  = 3'd5;

   // accumulator operations on the registered product
   localparam logic [1:0] ACC_NONE   = 2'd0;
   localparam logic [1:0] ACC_LOAD   = 2'd1;
   localparam logic [1:0] ACC_SUB    = 2'd2;
   localparam logic [1:0] ACC_ADD_SH = 2'd3;

   // datapath actions
   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_LP     = 3'd1;
   localparam logic [2:0] ACT_HP     = 3'd2;
   localparam logic [2:0] ACT_CLAMP  = 3'd3;
   localparam logic [2:0] ACT_FINISH = 3'd4;

   // program addresses
   localparam logic [STEP_W-1:0] UC_LP_GAIN  = 4'd0;
   localparam logic [STEP_W-1:0] UC_LP_FB1   = 4'd1;
   localparam logic [STEP_W-1:0] UC_LP_FB2   = 4'd2;
   localparam logic [STEP_W-1:0] UC_LP_SUM   = 4'd3;
   localparam logic [STEP_W-1:0] UC_LP_ROUND = 4'd4;
   localparam logic [STEP_W-1:0] UC_HP_SUB   = 4'd5;
   localparam logic [STEP_W-1:0] UC_CLAMP    = 4'd6;
   localparam logic [STEP_W-1:0] UC_POS_NORM = 4'd7;
   localparam logic [STEP_W-1:0] UC_POS_ACC  = 4'd8;
   localparam logic [STEP_W-1:0] UC_POS_SUM  = 4'd9;
   localparam logic [STEP_W-1:0] UC_FINISH   = 4'd10;

   typedef struct packed {
      logic [2:0]        mul_sel;
      logic [1:0]        acc_op;
      logic [2:0]        act;
      logic              jmp_hp_off;
      logic [STEP_W-1:0] jmp_to;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{mul_sel: MUL_HP_GAIN, acc_op: ACC_NONE, act: ACT_NONE,
            jmp_hp_off: 1'b0, jmp_to: UC_LP_GAIN};
      unique case (step)
         UC_LP_GAIN: begin
            w.mul_sel    = MUL_HP_GAIN;
            w.jmp_hp_off = 1'b1;
            w.jmp_to     = UC_HP_SUB;
         end
         UC_LP_FB1: begin
            w.mul_sel = MUL_HP_FB1;
            w.acc_op  = ACC_LOAD;
         end
         UC_LP_FB2: begin
            w.mul_sel = MUL_HP_FB2;
            w.acc_op  = ACC_SUB;
         end
         UC_LP_SUM:   w.acc_op = ACC_SUB;
         UC_LP_ROUND: w.act    = ACT_LP;
         UC_HP_SUB:   w.act    = ACT_HP;
         UC_CLAMP: begin
            w.act     = ACT_CLAMP;
            w.mul_sel = MUL_POS_HIST;
         end
         UC_POS_NORM: begin
            w.mul_sel = MUL_POS_NORM;
            w.acc_op  = ACC_LOAD;
         end
         UC_POS_ACC: begin
            w.mul_sel = MUL_POS_ACC;
            w.acc_op  = ACC_SUB;
         end
         UC_POS_SUM: w.acc_op = ACC_ADD_SH;
         UC_FINISH:  w.act    = ACT_FINISH;
         default:    w.act    = ACT_FINISH;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/twc_req_if.sv
// Sample input channel.
`default_nettype none

interface twc_req_if #(parameter int SAMPLE_WIDTH = 24);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] accel_sample;

   modport source (output valid, output accel_sample, input ready);
   modport sink   (input valid, input accel_sample, output ready);
endinterface

`default_nettype wire

// File: rtl/core/twc_rsp_if.sv
// Result output channel.
`default_nettype none

interface twc_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [twc_pkg::POS_WIDTH-1:0]  displacement;
   logic                                  was_clamped;

   modport source (output valid, output displacement, output was_clamped, input ready);
   modport sink   (input valid, input displacement, input was_clamped, output ready);
endinterface

`default_nettype wire

// File: rtl/core/twc_csr_if.sv
// Register write channel.
`default_nettype none

interface twc_csr_if #(parameter int DATA_WIDTH = 32);
   logic                               valid;
   logic                               ready;
   logic [twc_pkg::CSR_INDEX_W-1:0]    index;
   logic [DATA_WIDTH-1:0]              data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/translational_washout_channel_unit.sv
// Translational washout channel: microcoded high-pass, clamp and position filter.
//
// One acceleration item in, one displacement item out. A short program in a
// constant table steps a single shared coefficient multiplier and a wide
// accumulator, one step per cycle, except that the finishing step waits for
// the result register to empty. With the high-pass off the program jumps
// past its low-pass steps. The next item is accepted once the result is
// registered. The multiplier is used on six of the program's steps. A finished
// result sits in an output register, so the next item is taken while it waits.
// Registers are to be written only while no item is in flight; the block
// itself does not enforce it.
`default_nettype none

module translational_washout_channel_unit #(
   parameter int SAMPLE_WIDTH = 24,
   parameter int COEF_WIDTH   = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   twc_req_if.sink   req_if,
   twc_rsp_if.source rsp_if,
   twc_csr_if.sink   csr_if
);
   import twc_pkg::*;

   localparam int LIMIT_W = SAMPLE_WIDTH - 1;
   localparam int SUM_W   = SAMPLE_WIDTH + 2;
   localparam int D_W     = SAMPLE_WIDTH + 1;
   localparam int MB_W    = (SUM_W > POS_WIDTH) ? SUM_W : POS_WIDTH;
   localparam int WIDE    = (MB_W > SAMPLE_WIDTH + ACC_ALIGN) ? MB_W
                                                              : SAMPLE_WIDTH + ACC_ALIGN;
   localparam int PROD_W  = COEF_WIDTH + MB_W;
   localparam int ACC_W   = COEF_WIDTH + WIDE + 2;

   localparam logic signed [ACC_W-1:0] S_MAX =
      {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] S_MIN = ~S_MAX;
   localparam logic signed [ACC_W-1:0] P_MAX =
      {{(ACC_W-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] P_MIN = ~P_MAX;
   localparam logic signed [ACC_W-1:0] HALF  = {{(ACC_W-FRAC_SHIFT-1){1'b0}}, 1'b1,
                                                {(FRAC_SHIFT-1){1'b0}}};
   localparam logic signed [D_W-1:0] H_MAX = {2'b00, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [D_W-1:0] H_MIN = ~H_MAX;

   // configuration
   logic signed [COEF_WIDTH-1:0] hp_gain_ff, hp_fb_one_ff, hp_fb_two_ff;
   logic signed [COEF_WIDTH-1:0] pos_hist_ff, pos_norm_ff, pos_acc_ff;
   logic                         hp_enable_ff;
   logic [LIMIT_W-1:0]           limit_ff;

   // filter state
   logic signed [SAMPLE_WIDTH-1:0] in_prev_one_ff, in_prev_two_ff;
   logic signed [SAMPLE_WIDTH-1:0] lp_prev_one_ff, lp_prev_two_ff;
   logic signed [POS_WIDTH-1:0]    pos_prev_one_ff, pos_prev_two_ff;

   // sequencer and datapath
   logic                           busy_ff;
   logic [STEP_W-1:0]              step_ff, step_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff, lp_ff, a_pre_ff, a_ff;
   logic                           clamp_ff;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic                           rsp_valid_ff;
   logic signed [POS_WIDTH-1:0]    disp_ff;
   logic                           rsp_clamp_ff;

   ucode_type                      uc;
   logic signed [SUM_W-1:0]        tap_sum;
   logic signed [COEF_WIDTH-1:0]   coef_mux;
   logic signed [MB_W-1:0]         opb_mux;
   logic signed [ACC_W-1:0]        prod_ext, rnd;
   logic signed [SAMPLE_WIDTH-1:0] lp_sat, hp_sat, a_clamp;
   logic signed [D_W-1:0]          hp_diff, ap, lim_s, lim_n;
   logic signed [POS_WIDTH-1:0]    pos_sat;
   logic                           a_flag, out_free, fin, adv, req_acc;

   assign uc       = ucode_rom(step_ff);
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign fin      = busy_ff && (uc.act == ACT_FINISH);
   assign adv      = busy_ff && (!fin || out_free);
   assign req_acc  = req_if.valid && !busy_ff;

   assign req_if.ready        = !busy_ff;
   assign csr_if.ready        = 1'b1;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.displacement = disp_ff;
   assign rsp_if.was_clamped  = rsp_clamp_ff;

   assign tap_sum = SUM_W'(x_ff) + (SUM_W'(in_prev_one_ff) <<< 1) + SUM_W'(in_prev_two_ff);

   always_comb begin
      case (uc.mul_sel)
         MUL_HP_GAIN:  begin coef_mux = hp_gain_ff;   opb_mux = MB_W'(tap_sum);         end
         MUL_HP_FB1:   begin coef_mux = hp_fb_one_ff; opb_mux = MB_W'(lp_prev_one_ff);  end
         MUL_HP_FB2:   begin coef_mux = hp_fb_two_ff; opb_mux = MB_W'(lp_prev_two_ff);  end
         MUL_POS_HIST: begin coef_mux = pos_hist_ff;  opb_mux = MB_W'(pos_prev_one_ff); end
         MUL_POS_NORM: begin coef_mux = pos_norm_ff;  opb_mux = MB_W'(pos_prev_two_ff); end
         MUL_POS_ACC:  begin coef_mux = pos_acc_ff;   opb_mux = MB_W'(a_ff);            end
         default:      begin coef_mux = pos_acc_ff;   opb_mux = MB_W'(a_ff);            end
      endcase
   end

   assign prod_in  = coef_mux * opb_mux;
   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      case (uc.acc_op)
         ACC_LOAD:   acc_in = prod_ext;
         ACC_SUB:    acc_in = acc_ff - prod_ext;
         ACC_ADD_SH: acc_in = acc_ff + (prod_ext <<< ACC_ALIGN);
         default:    acc_in = acc_ff;
      endcase
   end

   // round to nearest, ties up, then saturate
   assign rnd = (acc_ff + HALF) >>> FRAC_SHIFT;

   always_comb begin
      if (rnd > S_MAX) begin
         lp_sat = S_MAX[SAMPLE_WIDTH-1:0];
      end else if (rnd < S_MIN) begin
         lp_sat = S_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         lp_sat = rnd[SAMPLE_WIDTH-1:0];
      end
      if (rnd > P_MAX) begin
         pos_sat = P_MAX[POS_WIDTH-1:0];
      end else if (rnd < P_MIN) begin
         pos_sat = P_MIN[POS_WIDTH-1:0];
      end else begin
         pos_sat = rnd[POS_WIDTH-1:0];
      end
   end

   assign hp_diff = D_W'(x_ff) - D_W'(lp_ff);

   always_comb begin
      if (hp_diff > H_MAX) begin
         hp_sat = H_MAX[SAMPLE_WIDTH-1:0];
      end else if (hp_diff < H_MIN) begin
         hp_sat = H_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         hp_sat = hp_diff[SAMPLE_WIDTH-1:0];
      end
   end

   assign ap    = D_W'(a_pre_ff);
   assign lim_s = {2'b00, limit_ff};
   assign lim_n = -lim_s;

   always_comb begin
      a_flag  = 1'b1;
      a_clamp = a_pre_ff;
      if (ap > lim_s) begin
         a_clamp = lim_s[SAMPLE_WIDTH-1:0];
      end else if (ap < lim_n) begin
         a_clamp = lim_n[SAMPLE_WIDTH-1:0];
      end else begin
         a_flag = 1'b0;
      end
   end

   always_comb begin
      if (uc.jmp_hp_off && !hp_enable_ff) begin
         step_in = uc.jmp_to;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hp_gain_ff   <= '0;
         hp_fb_one_ff <= '0;
         hp_fb_two_ff <= '0;
         hp_enable_ff <= 1'b1;
         limit_ff     <= LIMIT_W'(LIMIT_RESET);
         pos_hist_ff  <= COEF_WIDTH'(POS_HIST_RESET);
         pos_norm_ff  <= COEF_WIDTH'(POS_NORM_RESET);
         pos_acc_ff   <= COEF_WIDTH'(POS_ACC_RESET);
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_HP_GAIN:   hp_gain_ff   <= csr_if.data[COEF_WIDTH-1:0];
            REG_HP_FB_ONE: hp_fb_one_ff <= csr_if.data[COEF_WIDTH-1:0];
            REG_HP_FB_TWO: hp_fb_two_ff <= csr_if.data[COEF_WIDTH-1:0];
            REG_HP_ENABLE: hp_enable_ff <= csr_if.data[0];
            REG_LIMIT:     limit_ff     <= csr_if.data[LIMIT_W-1:0];
            REG_POS_HIST:  pos_hist_ff  <= csr_if.data[COEF_WIDTH-1:0];
            REG_POS_NORM:  pos_norm_ff  <= csr_if.data[COEF_WIDTH-1:0];
            REG_POS_ACC:   pos_acc_ff   <= csr_if.data[COEF_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // sequencer, filter state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         step_ff         <= UC_LP_GAIN;
         rsp_valid_ff    <= 1'b0;
         in_prev_one_ff  <= '0;
         in_prev_two_ff  <= '0;
         lp_prev_one_ff  <= '0;
         lp_prev_two_ff  <= '0;
         pos_prev_one_ff <= '0;
         pos_prev_two_ff <= '0;
      end else begin
         if (req_acc) begin
            busy_ff <= 1'b1;
            step_ff <= UC_LP_GAIN;
         end else if (adv) begin
            step_ff <= step_in;
            if (fin) begin
               busy_ff <= 1'b0;
            end
         end
         if (fin && out_free) begin
            rsp_valid_ff    <= 1'b1;
            pos_prev_two_ff <= pos_prev_one_ff;
            pos_prev_one_ff <= pos_sat;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (busy_ff && uc.act == ACT_HP && hp_enable_ff) begin
            in_prev_two_ff <= in_prev_one_ff;
            in_prev_one_ff <= x_ff;
            lp_prev_two_ff <= lp_prev_one_ff;
            lp_prev_one_ff <= lp_ff;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         x_ff <= req_if.accel_sample;
      end
      if (adv) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
      if (busy_ff && uc.act == ACT_LP) begin
         lp_ff <= lp_sat;
      end
      if (busy_ff && uc.act == ACT_HP) begin
         a_pre_ff <= hp_enable_ff ? hp_sat : x_ff;
      end
      if (busy_ff && uc.act == ACT_CLAMP) begin
         a_ff     <= a_clamp;
         clamp_ff <= a_flag;
      end
      if (fin && out_free) begin
         disp_ff      <= pos_sat;
         rsp_clamp_ff <= clamp_ff;
      end
   end

   a_start : assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (busy_ff && step_ff == UC_LP_GAIN))
      else $error("item taken without starting the program");

   a_step_range : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= UC_FINISH))
      else $error("step counter outside the program");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("result raised without an item in flight");

   a_hp_hold : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !hp_enable_ff) |=> ($stable(in_prev_one_ff) && $stable(lp_prev_one_ff)))
      else $error("high-pass history moved while bypassed");

endmodule

`default_nettype wire
